// ===== hdl/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg: shared definitions for the best-fit heap allocator
// Table entry layout, sizing constants, status and register codes.
// ----------------------------------------------------------------------------
package bfha_pkg;

  // table sizing
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // heap geometry (PAGE_BYTES is a power of two)
  localparam int PAGE_BYTES = 4096;
  localparam int HDR_BYTES  = 32;
  localparam int MIN_DATA   = 2;
  localparam int GROW_BYTES = 2 * PAGE_BYTES;

  // register reset values
  localparam logic [31:0] HEAP_BASE_RST  = 32'h0010_0000;
  localparam logic [31:0] HEAP_LIMIT_RST = 32'h0010_0000;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  // result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_LIMIT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  // one block table entry
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        is_free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/bfha_ram.sv =====
// ----------------------------------------------------------------------------
// bfha_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/best_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit: best-fit heap allocator with coalescing
// Block table lives in one RAM; a sequencer scans, grows, splits and merges.
// ----------------------------------------------------------------------------
// Null/zero-size requests answer the cycle after start. A free runs a match scan
// and then a merge pass. An allocate rounds the size, runs a fit scan (two
// scans if the heap grows), grants, shifts entries up for a split, then runs
// the merge pass and gives the result.
// One request at a time; the table RAM port sets the pace, one entry a cycle.
// Reset clears the entry count and heap size; no clearing pass is needed.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [30:0] request_size,
  input  logic [31:0] release_address,
  output logic        done,
  output logic [31:0] data_address,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  import bfha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NEED, S_FSCAN, S_BSCAN, S_GRANT, S_SH_RD, S_SH_WR, S_GR_WR, S_MERGE
  } state_t;

  state_t state;

  logic [31:0]      heap_base, heap_limit, heap_end;
  logic [CNT_W-1:0] count, rd_ptr, wr_ptr, shift_ptr, shift_prev;
  logic             pend;
  logic [IDX_W-1:0] pend_idx, hit_idx;
  logic             found, grown, have_cur;
  entry_t           hit, cur, last, rd_entry;
  logic [31:0]      need, best_diff, diff;
  logic [30:0]      size_q;
  logic [31:0]      rel_q;
  logic [32:0]      grow, grow_raw;
  logic [33:0]      end_sum;

  logic             scan_end, addr_match, fits, better;
  logic             new_entry, full, over, split, merge_join;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wentry;
  logic [ENTRY_W-1:0] ram_rdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // table storage
  bfha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = ram_rdata;

  // datapath terms
  assign scan_end   = (rd_ptr == count) && !pend;
  assign addr_match = (heap_base + rd_entry.offset + 32'(HDR_BYTES)) == rel_q;
  assign diff       = rd_entry.size - need;
  assign fits       = rd_entry.is_free && (rd_entry.size >= need);
  assign better     = !found || (diff < best_diff);
  assign new_entry  = (count == '0) || !last.is_free;
  assign full       = new_entry && (count >= CNT_W'(MAX_BLOCKS));
  assign end_sum    = {2'b00, heap_end} + {1'b0, grow};
  assign over       = end_sum > {2'b00, heap_limit};
  assign split      = ({1'b0, hit.size} > ({1'b0, need} + 33'(HDR_BYTES + MIN_DATA)))
                      && (count < CNT_W'(MAX_BLOCKS));
  assign merge_join = have_cur && cur.is_free && rd_entry.is_free;
  assign grow_raw   = ({1'b0, need} + 33'(HDR_BYTES + GROW_BYTES - 1))
                      & ~33'(GROW_BYTES - 1);
  assign shift_prev = shift_ptr - 1'b1;

  // table read address
  always_comb begin
    if (state == S_SH_RD) begin
      ram_raddr = shift_prev[IDX_W-1:0];
    end else begin
      ram_raddr = rd_ptr[IDX_W-1:0];
    end
  end

  // table write port
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = hit_idx;
    ram_wentry = hit;
    unique case (state)
      S_FSCAN: begin
        if (scan_end && found) begin
          ram_we             = 1'b1;
          ram_wentry.is_free = 1'b1;
        end
      end
      S_BSCAN: begin
        if (scan_end && !found && !grown && !full && !over) begin
          ram_we = 1'b1;
          if (new_entry) begin
            ram_waddr  = count[IDX_W-1:0];
            ram_wentry = '{offset: heap_end, size: grow[31:0] - 32'(HDR_BYTES),
                           is_free: 1'b1};
          end else begin
            ram_waddr  = IDX_W'(count - 1'b1);
            ram_wentry = '{offset: last.offset, size: last.size + grow[31:0],
                           is_free: 1'b1};
          end
        end
      end
      S_GRANT: begin
        if (!split) begin
          ram_we             = 1'b1;
          ram_wentry.is_free = 1'b0;
        end
      end
      S_SH_RD: begin
        if (shift_ptr <= ({1'b0, hit_idx} + 1'b1)) begin
          ram_we     = 1'b1;
          ram_waddr  = hit_idx + 1'b1;
          ram_wentry = '{offset: hit.offset + 32'(HDR_BYTES) + need,
                         size: hit.size - need - 32'(HDR_BYTES), is_free: 1'b1};
        end
      end
      S_SH_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = shift_ptr[IDX_W-1:0];
        ram_wentry = rd_entry;
      end
      S_GR_WR: begin
        ram_we     = 1'b1;
        ram_wentry = '{offset: hit.offset, size: need, is_free: 1'b0};
      end
      S_MERGE: begin
        if ((pend && have_cur && !merge_join) || (scan_end && have_cur)) begin
          ram_we     = 1'b1;
          ram_waddr  = wr_ptr[IDX_W-1:0];
          ram_wentry = cur;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer, registers and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      heap_end   <= '0;
      heap_base  <= HEAP_BASE_RST;
      heap_limit <= HEAP_LIMIT_RST;
      done       <= 1'b0;
      pend       <= 1'b0;
      rd_ptr     <= '0;
    end else begin
      done <= 1'b0;

      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_HEAP_BASE:  heap_base  <= cfg_data;
          CFG_HEAP_LIMIT: heap_limit <= cfg_data;
          default:        heap_base  <= heap_base;
        endcase
      end

      // sequential table read, one entry a cycle
      if (state == S_FSCAN || state == S_BSCAN || state == S_MERGE) begin
        if (rd_ptr != count) begin
          rd_ptr   <= rd_ptr + 1'b1;
          pend     <= 1'b1;
          pend_idx <= rd_ptr[IDX_W-1:0];
        end else begin
          pend <= 1'b0;
        end
      end else begin
        pend <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            size_q       <= request_size;
            rel_q        <= release_address;
            found        <= 1'b0;
            grown        <= 1'b0;
            have_cur     <= 1'b0;
            rd_ptr       <= '0;
            wr_ptr       <= '0;
            data_address <= '0;
            if (kind == KIND_FREE) begin
              if (release_address == '0) begin
                status <= ST_NULL;
                done   <= 1'b1;
              end else begin
                state <= S_FSCAN;
              end
            end else if (request_size == '0) begin
              status <= ST_NULL;
              done   <= 1'b1;
            end else begin
              need  <= 32'(MIN_DATA);
              state <= S_NEED;
            end
          end
        end
        // round the size up to a power of two
        S_NEED: begin
          if (need < {1'b0, size_q}) begin
            need <= need << 1;
          end else begin
            grow  <= grow_raw;
            state <= S_BSCAN;
          end
        end
        // look for the block to release
        S_FSCAN: begin
          if (pend && !found && addr_match) begin
            found   <= 1'b1;
            hit_idx <= pend_idx;
            hit     <= rd_entry;
          end
          if (scan_end) begin
            status <= found ? ST_DONE : ST_UNKNOWN;
            rd_ptr <= '0;
            state  <= S_MERGE;
          end
        end
        // best-fit scan, growth and retry
        S_BSCAN: begin
          if (pend) begin
            last <= rd_entry;
            if (fits && better) begin
              found     <= 1'b1;
              hit_idx   <= pend_idx;
              hit       <= rd_entry;
              best_diff <= diff;
            end
          end
          if (scan_end) begin
            rd_ptr <= '0;
            if (found) begin
              state <= S_GRANT;
            end else if (grown || over) begin
              status <= (grown || !full) ? ST_LIMIT : ST_FULL;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else if (full) begin
              status <= ST_FULL;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              if (new_entry) begin
                count <= count + 1'b1;
              end
              heap_end <= heap_end + grow[31:0];
              grown    <= 1'b1;
            end
          end
        end
        S_GRANT: begin
          data_address <= heap_base + hit.offset + 32'(HDR_BYTES);
          status       <= ST_DONE;
          shift_ptr    <= count;
          rd_ptr       <= '0;
          state        <= split ? S_SH_RD : S_MERGE;
        end
        // open a slot after the granted block, top entry first
        S_SH_RD: begin
          if (shift_ptr > ({1'b0, hit_idx} + 1'b1)) begin
            state <= S_SH_WR;
          end else begin
            count <= count + 1'b1;
            state <= S_GR_WR;
          end
        end
        S_SH_WR: begin
          shift_ptr <= shift_prev;
          state     <= S_SH_RD;
        end
        S_GR_WR: begin
          state <= S_MERGE;
        end
        // compaction pass: join runs of free blocks
        S_MERGE: begin
          if (pend) begin
            if (!have_cur) begin
              cur      <= rd_entry;
              have_cur <= 1'b1;
            end else if (merge_join) begin
              cur.size <= cur.size + rd_entry.size + 32'(HDR_BYTES);
            end else begin
              wr_ptr <= wr_ptr + 1'b1;
              cur    <= rd_entry;
            end
          end
          if (scan_end) begin
            count <= have_cur ? wr_ptr + 1'b1 : '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS))
    else $error("entry count above table depth");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ({1'b0, ram_waddr} <= count))
    else $error("table write beyond live entries");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("sequencer left idle without a request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while sequencer active");
`endif

endmodule
